// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define PSFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside of reset.
`define PSFP_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/psfp_pkg.sv -----
`default_nettype none

package psfp_pkg;

  localparam int unsigned FrameBytesDef = 32;
  localparam int unsigned PosW = 6;

  localparam logic [7:0] HdrFirst  = 8'h42;
  localparam logic [7:0] HdrSecond = 8'h4D;

  localparam logic [PosW-1:0] Pm1HiPos  = PosW'(10);
  localparam logic [PosW-1:0] Pm1LoPos  = PosW'(11);
  localparam logic [PosW-1:0] Pm25HiPos = PosW'(12);
  localparam logic [PosW-1:0] Pm25LoPos = PosW'(13);
  localparam logic [PosW-1:0] Pm10HiPos = PosW'(14);
  localparam logic [PosW-1:0] Pm10LoPos = PosW'(15);

  typedef struct packed {
    logic [15:0] pm1_0;
    logic [15:0] pm2_5;
    logic [15:0] pm10;
  } pm_result_t;

endpackage

`default_nettype wire

// ----- rtl/particulate_sensor_frame_parser.sv -----
`default_nettype none

// Particulate sensor frame parser. Each accepted request carries one byte from the
// sensor's serial link; the block hunts for the 0x42 0x4D header, sums the frame,
// captures the PM1.0, PM2.5 and PM10 words and, when the big-endian trailer matches
// the 16-bit sum, delivers one result with the three readings; a bad frame yields
// nothing. A byte is taken in every cycle while the input is not stalled: it passes
// an input register and is parsed by combinational logic, and a result lands in an
// output register. Only a held output register, with a result waiting and the
// output stalled, stalls the input.

module particulate_sensor_frame_parser
  import psfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pm1_0_o,
  output logic [15:0]      pm2_5_o,
  output logic [15:0]      pm10_o
);

  logic       res_valid;
  logic       res_ready;
  pm_result_t res;

  psfp_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .res_ready_i(res_ready),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  psfp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .res_ready_o(res_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pm1_0_o    (pm1_0_o),
    .pm2_5_o    (pm2_5_o),
    .pm10_o     (pm10_o)
  );

endmodule

`default_nettype wire

// ----- rtl/psfp_core.sv -----
`default_nettype none

module psfp_core
  import psfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       res_ready_i,
  output logic            res_valid_o,
  output pm_result_t      res_o
);

  localparam logic [1:0] PhHunt1   = 2'd0;
  localparam logic [1:0] PhHunt2   = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  localparam logic [PosW-1:0] TrailHiPos = PosW'(FRAME_BYTES - 2);

  logic [7:0]      byte_q;
  logic            byte_vld_q, byte_vld_d;
  logic            accept;
  logic            adv;

  logic [1:0]      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;
  logic [15:0]     pm1_q, pm1_d;
  logic [15:0]     pm25_q, pm25_d;
  logic [15:0]     pm10_q, pm10_d;
  logic [7:0]      trail_hi_q, trail_hi_d;
  logic            match;

  assign in_stall_o = byte_vld_q && !res_ready_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = byte_vld_q && res_ready_i;

  always_comb begin
    byte_vld_d = byte_vld_q;
    if (accept) begin
      byte_vld_d = 1'b1;
    end else if (adv) begin
      byte_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else begin
      byte_vld_q <= byte_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
    end
  end

  assign match = ({trail_hi_q, byte_q} == sum_q);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    pm1_d       = pm1_q;
    pm25_d      = pm25_q;
    pm10_d      = pm10_q;
    trail_hi_d  = trail_hi_q;
    res_valid_o = 1'b0;
    if (adv) begin
      case (phase_q)
        PhHunt1: begin
          if (byte_q == HdrFirst) begin
            sum_d   = {8'h00, byte_q};
            pos_d   = PosW'(1);
            phase_d = PhHunt2;
          end
        end
        PhHunt2: begin
          if (byte_q == HdrSecond) begin
            sum_d   = sum_q + {8'h00, byte_q};
            pos_d   = PosW'(2);
            phase_d = PhCollect;
          end else begin
            pos_d   = '0;
            phase_d = PhHunt1;
          end
        end
        PhCollect: begin
          if (pos_q < TrailHiPos) begin
            sum_d = sum_q + {8'h00, byte_q};
            case (pos_q)
              Pm1HiPos:  pm1_d[15:8]  = byte_q;
              Pm1LoPos:  pm1_d[7:0]   = byte_q;
              Pm25HiPos: pm25_d[15:8] = byte_q;
              Pm25LoPos: pm25_d[7:0]  = byte_q;
              Pm10HiPos: pm10_d[15:8] = byte_q;
              Pm10LoPos: pm10_d[7:0]  = byte_q;
              default: ;
            endcase
            pos_d = pos_q + PosW'(1);
          end else if (pos_q == TrailHiPos) begin
            trail_hi_d = byte_q;
            pos_d      = pos_q + PosW'(1);
          end else begin
            res_valid_o = match;
            pos_d       = '0;
            phase_d     = PhHunt1;
          end
        end
        default: begin
          pos_d   = '0;
          phase_d = PhHunt1;
        end
      endcase
    end
  end

  assign res_o.pm1_0 = pm1_q;
  assign res_o.pm2_5 = pm25_q;
  assign res_o.pm10  = pm10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHunt1;
      pos_q      <= '0;
      sum_q      <= '0;
      pm1_q      <= '0;
      pm25_q     <= '0;
      pm10_q     <= '0;
      trail_hi_q <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      pm1_q      <= pm1_d;
      pm25_q     <= pm25_d;
      pm10_q     <= pm10_d;
      trail_hi_q <= trail_hi_d;
    end
  end

`include "assert_macros.svh"

  `PSFP_ASSERT(a_hunt_pos_zero, clk_i, rst_ni, (phase_q == PhHunt1) |-> (pos_q == '0), "hunt phase with nonzero position")
  `PSFP_ASSERT(a_res_from_collect, clk_i, rst_ni, res_valid_o |-> (adv && (phase_q == PhCollect) && (pos_q > TrailHiPos)), "result outside frame end")
  `PSFP_ASSERT(a_end_to_hunt, clk_i, rst_ni, (adv && (phase_q == PhCollect) && (pos_q > TrailHiPos)) |=> (phase_q == PhHunt1), "frame end did not return to hunt")

endmodule

`default_nettype wire

// ----- rtl/psfp_out_reg.sv -----
`default_nettype none

module psfp_out_reg
  import psfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        res_valid_i,
  input  wire pm_result_t  res_i,
  output logic             res_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pm1_0_o,
  output logic [15:0]      pm2_5_o,
  output logic [15:0]      pm10_o
);

  logic       vld_q;
  pm_result_t data_q;

  assign res_ready_o = !vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (res_ready_o) begin
      vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign pm1_0_o     = data_q.pm1_0;
  assign pm2_5_o     = data_q.pm2_5;
  assign pm10_o      = data_q.pm10;

`include "assert_macros.svh"

  `PSFP_NEVER(a_no_overwrite, clk_i, rst_ni, res_valid_i && !res_ready_o, "result while held")

endmodule

`default_nettype wire

// ----- tb/particulate_sensor_frame_parser_tb.sv -----
`timescale 1ns / 1ps

module particulate_sensor_frame_parser_tb;
  import psfp_pkg::*;

  localparam int unsigned FrameLen = FrameBytesDef;
  localparam int unsigned LastPos = FrameLen - 1;
  localparam int RandomFill = -1;
  localparam int RandomBytes = 1400;
  localparam int MinGoodFrames = 40;
  localparam int LongHoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 500000;

  typedef enum logic [1:0] {
    PhHuntFirst,
    PhHuntSecond,
    PhCollect,
    PhUnused
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] pm1_0_o;
  logic [15:0] pm2_5_o;
  logic [15:0] pm10_o;

  parse_phase_e phase;
  logic [PosW-1:0] frame_pos;
  logic [15:0] frame_sum;
  logic [15:0] cap_pm1;
  logic [15:0] cap_pm25;
  logic [15:0] cap_pm10;
  logic [7:0]  trailer_hi;
  pm_result_t  pm_expected_q[$];

  bit send_gaps_on = 1'b1;
  bit stall_bursts_on = 1'b1;
  bit long_hold_req = 1'b0;
  int hold_left = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int frames_matched = 0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;

  particulate_sensor_frame_parser #(
    .FRAME_BYTES(FrameLen)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pm1_0_o(pm1_0_o),
    .pm2_5_o(pm2_5_o),
    .pm10_o(pm10_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left = LongHoldCycles;
      long_hold_req = 1'b0;
    end
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (stall_bursts_on && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(1, 13) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    pm_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pm_expected_q.size() == 0) begin
        $error("Unexpected reading: pm1_0=%h pm2_5=%h pm10=%h", pm1_0_o, pm2_5_o, pm10_o);
        error_count++;
      end else begin
        want = pm_expected_q.pop_front();
        if (pm1_0_o !== want.pm1_0) begin
          $error("pm1_0 mismatch: expected %h, got %h", want.pm1_0, pm1_0_o);
          error_count++;
        end
        if (pm2_5_o !== want.pm2_5) begin
          $error("pm2_5 mismatch: expected %h, got %h", want.pm2_5, pm2_5_o);
          error_count++;
        end
        if (pm10_o !== want.pm10) begin
          $error("pm10 mismatch: expected %h, got %h", want.pm10, pm10_o);
          error_count++;
        end
      end
    end
  end

  task automatic clear_parser_state();
    phase = PhHuntFirst;
    frame_pos = '0;
    frame_sum = '0;
    cap_pm1 = '0;
    cap_pm25 = '0;
    cap_pm10 = '0;
    trailer_hi = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] trailer;
    case (phase)
      PhHuntFirst: begin
        if (b == HdrFirst) begin
          frame_sum = {8'h00, b};
          frame_pos = PosW'(1);
          phase = PhHuntSecond;
        end
      end
      PhHuntSecond: begin
        if (b == HdrSecond) begin
          frame_sum = frame_sum + b;
          frame_pos = PosW'(2);
          phase = PhCollect;
        end else begin
          phase = PhHuntFirst;
          frame_pos = '0;
        end
      end
      PhCollect: begin
        if (frame_pos < LastPos - 1) begin
          frame_sum = frame_sum + b;
          case (frame_pos)
            Pm1HiPos:  cap_pm1[15:8] = b;
            Pm1LoPos:  cap_pm1[7:0] = b;
            Pm25HiPos: cap_pm25[15:8] = b;
            Pm25LoPos: cap_pm25[7:0] = b;
            Pm10HiPos: cap_pm10[15:8] = b;
            Pm10LoPos: cap_pm10[7:0] = b;
            default: ;
          endcase
          frame_pos = frame_pos + 1'b1;
        end else if (frame_pos == LastPos - 1) begin
          trailer_hi = b;
          frame_pos = frame_pos + 1'b1;
        end else begin
          trailer = {trailer_hi, b};
          phase = PhHuntFirst;
          frame_pos = '0;
          if (trailer == frame_sum) begin
            frames_matched++;
            pm_expected_q.push_back('{pm1_0: cap_pm1, pm2_5: cap_pm25, pm10: cap_pm10});
          end
        end
      end
      default: begin
        phase = PhHuntFirst;
        frame_pos = '0;
      end
    endcase
  endtask

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (send_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      data_byte_i <= 8'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    @(negedge clk_i);
    parse_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] p1, input logic [15:0] p25,
                            input logic [15:0] p10, input int fill, input bit corrupt);
    logic [7:0] fb [FrameLen];
    logic [15:0] csum;
    csum = '0;
    fb[0] = HdrFirst;
    fb[1] = HdrSecond;
    for (int i = 2; i < FrameLen - 2; i++) begin
      fb[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    end
    fb[Pm1HiPos] = p1[15:8];
    fb[Pm1LoPos] = p1[7:0];
    fb[Pm25HiPos] = p25[15:8];
    fb[Pm25LoPos] = p25[7:0];
    fb[Pm10HiPos] = p10[15:8];
    fb[Pm10LoPos] = p10[7:0];
    for (int i = 0; i < FrameLen - 2; i++) begin
      csum = csum + fb[i];
    end
    if (corrupt) begin
      csum = csum ^ 16'($urandom_range(1, 65535));
    end
    fb[FrameLen-2] = csum[15:8];
    fb[FrameLen-1] = csum[7:0];
    foreach (fb[i]) begin
      send_byte(fb[i]);
    end
  endtask

  task automatic wait_for_readings();
    while (pm_expected_q.size() != 0) @(negedge clk_i);
  endtask

  // A repeated first header byte is a wrong second byte and is not taken as the start of a new header.
  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HdrSecond);
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_frame(16'h1234, 16'h5678, 16'h9ABC, RandomFill, 1'b0);
  endtask

  task automatic test_extreme_frames();
    send_frame(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);
    send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 16'h8001, RandomFill, 1'b0);
  endtask

  task automatic test_bad_checksum();
    send_frame(16'hDEAD, 16'hBEEF, 16'hCAFE, RandomFill, 1'b1);
    send_frame(16'h0042, 16'h004D, 16'h4D42, RandomFill, 1'b0);
  endtask

  task automatic test_output_hold_off();
    long_hold_req = 1'b1;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    repeat (4) send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b0);
  endtask

  task automatic test_paused_sender();
    repeat (2) send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b0);
    in_valid_i <= 1'b0;
    wait_for_readings();
    send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b0);
  endtask

  task automatic test_random_stream();
    int stop_at;
    int kind;
    int n;
    logic [7:0] b;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at || frames_matched < MinGoodFrames) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b0);
      end else if (kind < 80) begin
        send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b1);
      end else if (kind < 90) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: b = HdrFirst;
            1: b = HdrSecond;
            default: b = 8'($urandom);
          endcase
          send_byte(b);
        end
      end else if (kind < 95) begin
        b = 8'($urandom);
        if (b == HdrSecond) begin
          b = ~b;
        end
        send_byte(HdrFirst);
        send_byte(b);
      end else begin
        n = $urandom_range(0, FrameLen - 3);
        send_byte(HdrFirst);
        send_byte(HdrSecond);
        repeat (n) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back();
    send_gaps_on = 1'b0;
    stall_bursts_on = 1'b0;
    repeat (8) send_frame(16'($urandom), 16'($urandom), 16'($urandom), RandomFill, 1'b0);
  endtask

  initial begin
    clear_parser_state();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_header_hunt();
    test_extreme_frames();
    test_bad_checksum();
    test_output_hold_off();
    test_paused_sender();
    test_random_stream();
    test_back_to_back();

    in_valid_i <= 1'b0;
    wait_for_readings();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered header hunting, extreme and corrupted frames, output hold-off,");
    $display("a random byte stream and a gap-free tail: %0d bytes, %0d readings checked.",
             bytes_sent, results_seen);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- particulate_sensor_frame_parser.f -----
+incdir+rtl
rtl/psfp_pkg.sv
rtl/psfp_core.sv
rtl/psfp_out_reg.sv
rtl/particulate_sensor_frame_parser.sv
tb/particulate_sensor_frame_parser_tb.sv
